>>> sv/taes_pkg.sv
package taes_pkg;

  // Block geometry
  localparam int BLK_BYTES = 16;
  localparam int BLK_ROWS  = 4;
  localparam int IDX_W     = $clog2(BLK_BYTES);

  // Key storage
  localparam int KEY_MAX   = 16;
  localparam int KEY_W     = 64;
  localparam int KLEN_W    = 5;

  // Pad byte for a short final block
  localparam logic [7:0] PAD_CHAR = 8'h41;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd2;

  // Block queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One padded block on its way to the back end
  typedef struct packed {
    logic [BLK_BYTES-1:0][7:0] bytes;
    logic                      last;
  } blk_t;

endpackage

>>> sv/taes_front.sv
module taes_front import taes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wr_data,
  // byte stream
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_plain_byte,
  input  logic                 in_message_end,
  // block push toward the queue
  input  logic                 q_full,
  output logic                 push_valid,
  output blk_t                 push_blk
);

  logic [KEY_W-1:0]      key_lo_r;
  logic [KEY_W-1:0]      key_hi_r;
  logic [KLEN_W-1:0]     key_len_r;
  logic [IDX_W-1:0]      key_pos_r, key_pos_nxt;
  logic [IDX_W-1:0]      fill_r, fill_nxt;
  logic [BLK_BYTES-1:0][7:0] store_r;

  logic                  xfer;
  logic                  kept;
  logic                  upper;
  logic [KLEN_W-1:0]     len_eff;
  logic [IDX_W-1:0]      pos_use;
  logic [IDX_W-1:0]      pos_adv;
  logic [2*KEY_W-1:0]    key_all;
  logic [7:0]            key_ch;
  logic [8:0]            sum;
  logic [17:0]           prod;
  logic [4:0]            quo;
  logic [8:0]            rem0;
  logic [8:0]            rem1;
  logic [7:0]            enc_byte;
  logic                  full_now;
  logic [IDX_W:0]        fill_after;

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= KEY_W'(65);
      key_hi_r  <= '0;
      key_len_r <= KLEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_LO:  key_lo_r  <= cfg_wr_data;
        CFG_KEY_HI:  key_hi_r  <= cfg_wr_data;
        CFG_KEY_LEN: key_len_r <= cfg_wr_data[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte class: spaces and punctuation are dropped
  always_comb begin
    kept  = !(in_plain_byte inside {[8'd32:8'd47], [8'd58:8'd64], [8'd91:8'd96],
                                    [8'd123:8'd126]});
    upper = in_plain_byte inside {[8'd65:8'd90]};
  end

  // Key length in use, clamped to 1..KEY_MAX, and current key position
  always_comb begin
    if (key_len_r == '0)
      len_eff = KLEN_W'(1);
    else if (key_len_r > KLEN_W'(KEY_MAX))
      len_eff = KLEN_W'(KEY_MAX);
    else
      len_eff = key_len_r;
    pos_use = ({1'b0, key_pos_r} >= len_eff) ? '0 : key_pos_r;
    pos_adv = ({1'b0, pos_use} + KLEN_W'(1) >= len_eff) ? '0 : pos_use + IDX_W'(1);
  end

  // Vigenere step: (p + k) mod 26 via reciprocal multiply and one correction
  always_comb begin
    key_all  = {key_hi_r, key_lo_r};
    key_ch   = key_all[{pos_use, 3'b000} +: 8];
    sum      = {1'b0, in_plain_byte} + {1'b0, key_ch};
    prod     = 18'(sum) * 18'(315);
    quo      = prod[17:13];
    rem0     = sum - 9'(quo) * 9'(26);
    rem1     = (rem0 >= 9'(26)) ? rem0 - 9'(26) : rem0;
    enc_byte = upper ? rem1[7:0] + 8'(65) : in_plain_byte;
  end

  // Block assembly: merge the incoming byte and pad the tail
  always_comb begin
    full_now   = kept && (fill_r == IDX_W'(BLK_BYTES - 1));
    fill_after = {1'b0, fill_r} + (IDX_W+1)'(kept);
    push_valid = xfer && (full_now || (in_message_end && fill_after != '0));
    push_blk.last = in_message_end;
    for (int i = 0; i < BLK_BYTES; i++) begin
      if (kept && fill_r == IDX_W'(i))
        push_blk.bytes[i] = enc_byte;
      else if ((IDX_W+1)'(i) < fill_after)
        push_blk.bytes[i] = store_r[i];
      else
        push_blk.bytes[i] = PAD_CHAR;
    end
  end

  // Fill count and key position for the next byte
  always_comb begin
    fill_nxt    = fill_r;
    key_pos_nxt = key_pos_r;
    if (xfer) begin
      if (kept) begin
        fill_nxt    = fill_after[IDX_W-1:0];
        key_pos_nxt = pos_adv;
      end
      if (in_message_end) begin
        fill_nxt    = '0;
        key_pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      key_pos_r <= '0;
    end else begin
      fill_r    <= fill_nxt;
      key_pos_r <= key_pos_nxt;
    end
  end

  // Block store, one write per kept byte
  always_ff @(posedge clk) begin
    if (xfer && kept)
      store_r[fill_r] <= enc_byte;
  end

endmodule

>>> sv/taes_queue.sv
module taes_queue import taes_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  blk_t push_blk,
  output logic q_full,
  output logic q_valid,
  output blk_t q_blk,
  input  logic q_pop
);

  blk_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_blk   = mem_r[rd_ptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = q_pop && q_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    if (do_push && !do_pop)
      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (do_pop && !do_push)
      cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= push_blk;
  end

endmodule

>>> sv/taes_back.sv
module taes_back import taes_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // block from the queue
  input  logic       q_valid,
  input  blk_t       q_blk,
  output logic       q_pop,
  // result stream
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_cipher_byte,
  output logic       out_block_end,
  output logic       out_message_done
);

  logic                      busy_r, busy_nxt;
  logic [IDX_W-1:0]          cnt_r, cnt_nxt;
  logic                      last_r;
  logic [BLK_BYTES-1:0][7:0] data_r;
  logic [BLK_BYTES-1:0][7:0] shuf;
  logic [BLK_BYTES-1:0][7:0] mixed;
  logic                      at_end;
  logic                      load;

  function automatic logic [7:0] gf_x2(input logic [7:0] a);
    gf_x2 = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_x3(input logic [7:0] a);
    gf_x3 = gf_x2(a) ^ a;
  endfunction

  // Row rotation and odd-parity MSB flip
  always_comb begin
    for (int r = 0; r < BLK_ROWS; r++) begin
      for (int c = 0; c < BLK_ROWS; c++) begin
        shuf[r*BLK_ROWS + c] = q_blk.bytes[r*BLK_ROWS + ((c + r) % BLK_ROWS)];
        if (^shuf[r*BLK_ROWS + c])
          shuf[r*BLK_ROWS + c][7] = ~shuf[r*BLK_ROWS + c][7];
      end
    end
  end

  // Column mix over GF(2^8)
  always_comb begin
    for (int c = 0; c < BLK_ROWS; c++) begin
      mixed[c]    = gf_x2(shuf[c]) ^ gf_x3(shuf[4+c]) ^ shuf[8+c] ^ shuf[12+c];
      mixed[4+c]  = shuf[c] ^ gf_x2(shuf[4+c]) ^ gf_x3(shuf[8+c]) ^ shuf[12+c];
      mixed[8+c]  = shuf[c] ^ shuf[4+c] ^ gf_x2(shuf[8+c]) ^ gf_x3(shuf[12+c]);
      mixed[12+c] = gf_x3(shuf[c]) ^ shuf[4+c] ^ shuf[8+c] ^ gf_x2(shuf[12+c]);
    end
  end

  // Emit sequencer: a new block loads as the last byte of the old one leaves
  always_comb begin
    at_end   = (cnt_r == IDX_W'(BLK_BYTES - 1));
    load     = q_valid && (!busy_r || (out_ready && at_end));
    q_pop    = load;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r && out_ready) begin
      if (at_end)
        busy_nxt = 1'b0;
      else
        cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= mixed;
      last_r <= q_blk.last;
    end
  end

  assign out_valid        = busy_r;
  assign out_cipher_byte  = data_r[cnt_r];
  assign out_block_end    = at_end;
  assign out_message_done = at_end && last_r;

endmodule

>>> sv/toy_aes_block_encrypter_core.sv
// Toy block encrypter core.
// Input channel (in_valid/in_ready): one plaintext byte per transfer, with
// in_message_end on the final byte of a message. Spaces and punctuation are
// dropped; uppercase letters get a repeating key shift; kept bytes fill
// 16-byte blocks. A message end pads a partial block with 'A'.
// Output channel (out_valid/out_ready): 16 bytes per block, row by row;
// out_block_end marks byte 16, out_message_done marks byte 16 of the block
// closed by a message end. An empty block at message end emits nothing.
// Config port: cfg_wr_en writes cfg_wr_data to register cfg_index (0 key
// low, 1 key high, 2 key length) at once; other indexes are ignored.
// Throughput: one input byte per cycle while the queue is not full; each block
// leaves as 16 output bytes through the single-byte output port of the back end.
// Path: a block closed by a transfer is written into the queue, then loaded into
// the back-end data register, which shows its first byte, when the back end is free.
// A two-block queue sits between the front and the back; in_ready drops only
// when it is full, so a stalled receiver backs up into the queue first.
// Reset clears the key registers to their defaults, the fill count, key
// position, queue and output sequencer; no clearing pass is needed.
module toy_aes_block_encrypter_core import taes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_plain_byte,
  input  logic                 in_message_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_cipher_byte,
  output logic                 out_block_end,
  output logic                 out_message_done
);

  logic push_valid;
  blk_t push_blk;
  logic q_full;
  logic q_valid;
  blk_t q_blk;
  logic q_pop;

  // Filter, encrypt and assemble blocks
  taes_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_plain_byte  (in_plain_byte),
    .in_message_end (in_message_end),
    .q_full         (q_full),
    .push_valid     (push_valid),
    .push_blk       (push_blk)
  );

  // Block queue
  taes_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_blk   (push_blk),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_blk      (q_blk),
    .q_pop      (q_pop)
  );

  // Mix and emit
  taes_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_blk            (q_blk),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cipher_byte  (out_cipher_byte),
    .out_block_end    (out_block_end),
    .out_message_done (out_message_done)
  );

endmodule

>>> sv/taes_checker.sv
module taes_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_cipher_byte,
  input logic       out_block_end,
  input logic       out_message_done
);

  // Result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_byte) &&
      $stable(out_block_end) && $stable(out_message_done))
    else $error("result changed during stall");

  // Message done only on a block's last byte
  a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done |-> out_block_end)
    else $error("message_done without block_end");

  // Reset empties the output side
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Reset empties the queue, so the input side is open
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind toy_aes_block_encrypter_core taes_checker u_taes_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_cipher_byte  (out_cipher_byte),
  .out_block_end    (out_block_end),
  .out_message_done (out_message_done)
);

>>> sim/tb_toy_aes_block_encrypter_core.sv
`timescale 1ns / 100ps

module tb_toy_aes_block_encrypter_core;
  import taes_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RX_HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

  typedef struct {
    logic [7:0] plain;
    logic       msg_end;
    bit         drain_first;
  } plain_item_t;

  typedef struct {
    logic [7:0] cipher;
    logic       blk_end;
    logic       msg_done;
  } cipher_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_plain_byte = '0;
  logic                 in_message_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_cipher_byte;
  logic                 out_block_end;
  logic                 out_message_done;

  toy_aes_block_encrypter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_plain_byte    (in_plain_byte),
    .in_message_end   (in_message_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cipher_byte  (out_cipher_byte),
    .out_block_end    (out_block_end),
    .out_message_done (out_message_done)
  );

  always #10 clk = ~clk;

  // Stimulus and expectation stores
  plain_item_t plain_pending[$];
  cipher_res_t cipher_expect[$];
  plain_item_t drv_item;
  cipher_res_t got_res;

  int  fail_cnt = 0;
  int  cycle_cnt = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  in_taken = 1'b0;
  bit  rx_hold_req = 1'b0;
  int  rx_hold_left = 0;

  // Cipher state as seen by the predictor
  logic [KEY_W-1:0]  key_lo;
  logic [KEY_W-1:0]  key_hi;
  logic [KLEN_W-1:0] key_len_reg;
  logic [7:0]        blk_bytes [BLK_BYTES];
  int                fill_cnt;
  int                key_pos;

  function automatic bit is_punct(logic [7:0] b);
    return (b >= 8'd32 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
           (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] key_byte(int idx);
    if (idx < 8) return key_lo[idx*8 +: 8];
    return key_hi[(idx-8)*8 +: 8];
  endfunction

  // Row shift, parity flip and MixColumns; queues 16 results row by row
  task automatic queue_block_cipher(input logic last);
    logic [7:0]  m [BLK_BYTES];
    logic [7:0]  res [BLK_BYTES];
    logic [7:0]  v;
    logic [7:0]  a0, a1, a2, a3;
    cipher_res_t r_item;
    for (int r = 0; r < BLK_ROWS; r++) begin
      for (int c = 0; c < 4; c++) begin
        v = blk_bytes[r*4 + ((c + r) & 3)];
        if (^v) v ^= 8'h80;
        m[r*4 + c] = v;
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = m[c]; a1 = m[4+c]; a2 = m[8+c]; a3 = m[12+c];
      res[c]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      res[4+c]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      res[8+c]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      res[12+c] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    for (int k = 0; k < BLK_BYTES; k++) begin
      r_item.cipher   = res[k];
      r_item.blk_end  = (k == BLK_BYTES - 1);
      r_item.msg_done = (k == BLK_BYTES - 1) && last;
      cipher_expect.insert(cipher_expect.size(), r_item);
    end
  endtask

  // One accepted plaintext byte: filter, key shift, block fill, flush
  task automatic absorb_plain(input logic [7:0] b, input logic last);
    int         len;
    logic [7:0] v;
    if (!is_punct(b)) begin
      len = key_len_reg;
      if (len == 0) len = 1;
      if (len > KEY_MAX) len = KEY_MAX;
      if (key_pos >= len) key_pos = 0;
      v = b;
      if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z)
        v = 8'((int'(b) + int'(key_byte(key_pos))) % 26 + int'(PAD_CHAR));
      key_pos = (key_pos + 1 >= len) ? 0 : key_pos + 1;
      blk_bytes[fill_cnt] = v;
      fill_cnt++;
      if (fill_cnt == BLK_BYTES) begin
        fill_cnt = 0;
        queue_block_cipher(last);
      end
    end
    if (last) begin
      if (fill_cnt != 0) begin
        for (int i = fill_cnt; i < BLK_BYTES; i++) blk_bytes[i] = PAD_CHAR;
        queue_block_cipher(1'b1);
      end
      fill_cnt = 0;
      key_pos = 0;
    end
  endtask

  // Register write at the next falling edge; the predictor follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    case (idx)
      CFG_KEY_LO:  key_lo = val;
      CFG_KEY_HI:  key_hi = val;
      CFG_KEY_LEN: key_len_reg = val[KLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_reg_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] rand_plain();
    int         sel;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 55) return 8'($urandom_range(ASCII_UPPER_Z, ASCII_UPPER_A));
    if (sel < 75) begin
      do b = 8'($urandom_range(126, 32)); while (!is_punct(b));
      return b;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic push_plain(input logic [7:0] b, input logic last, input bit drain);
    plain_item_t it;
    it.plain = b;
    it.msg_end = last;
    it.drain_first = drain;
    plain_pending.insert(plain_pending.size(), it);
  endtask

  // Messages of random text; the last one may be cut short.
  // pause_at >= 0 makes that item wait for all results first.
  task automatic push_messages(input int count, input int pause_at);
    int left;
    int msg_len;
    int n;
    left = count;
    n = 0;
    while (left > 0) begin
      msg_len = ($urandom_range(99) < 10) ? $urandom_range(90, 60) : $urandom_range(30, 1);
      for (int i = 0; i < msg_len && left > 0; i++) begin
        push_plain(rand_plain(), i == msg_len - 1, n == pause_at);
        left--;
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (plain_pending.size() > 0 || in_valid || cipher_expect.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (plain_pending.size() > 0 &&
          !(plain_pending[0].drain_first && cipher_expect.size() > 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        drv_item = plain_pending.pop_front();
        in_valid <= 1'b1;
        in_plain_byte <= drv_item.plain;
        in_message_end <= drv_item.msg_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with an occasional long hold-off
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Input transfers feed the predictor; output transfers are checked
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) absorb_plain(in_plain_byte, in_message_end);
    if (rst_n && out_valid && out_ready) begin
      if (cipher_expect.size() == 0) begin
        $error("unexpected output transfer: cipher_byte=%h", out_cipher_byte);
        fail_cnt++;
      end else begin
        got_res = cipher_expect.pop_front();
        if (out_cipher_byte !== got_res.cipher) begin
          $error("cipher_byte: expected %h, got %h", got_res.cipher, out_cipher_byte);
          fail_cnt++;
        end
        if (out_block_end !== got_res.blk_end) begin
          $error("block_end: expected %b, got %b", got_res.blk_end, out_block_end);
          fail_cnt++;
        end
        if (out_message_done !== got_res.msg_done) begin
          $error("message_done: expected %b, got %b", got_res.msg_done, out_message_done);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Directed bytes: field extremes, boundary punctuation, non-letters kept
  logic [7:0] short_msg [9] = '{8'h20, 8'h41, 8'h5A, 8'h00, 8'hFF, 8'h21, 8'h7E, 8'h60, 8'h4D};
  logic [7:0] full_msg [16] = '{8'h5A, 8'h41, 8'h30, 8'h39, 8'h61, 8'h7A, 8'h7F, 8'h80,
                                8'h1F, 8'h42, 8'h59, 8'hC3, 8'h4E, 8'h71, 8'h55, 8'h4B};

  initial begin
    key_lo = 64'd65;
    key_hi = '0;
    key_len_reg = 5'd1;
    fill_cnt = 0;
    key_pos = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset key; message end on a dropped byte with empty block,
    // padded short block, then a full block closed by message end
    send_idle_pct = 23;
    recv_idle_pct = 77;
    push_plain(short_msg[0], 1'b1, 1'b0);
    for (int i = 1; i < 9; i++) push_plain(short_msg[i], i == 8, 1'b0);
    for (int i = 0; i < 16; i++) push_plain(full_msg[i], i == 15, 1'b0);
    wait_drained();

    // Longest key, extreme key bytes; long receiver hold-off backs up the input
    write_reg(CFG_KEY_LO, ALL_ONES);
    write_reg(CFG_KEY_HI, rand_word());
    write_reg(CFG_KEY_LEN, {(KEY_W-KLEN_W)'(rand_word() >> KLEN_W), 5'd16});
    end_reg_writes();
    rx_hold_req = 1'b1;
    push_messages(64, -1);
    // leave a message open so the key position is well inside the key
    for (int i = 0; i < 7; i++) push_plain(8'h51, 1'b0, 1'b0);
    wait_drained();

    // Shrink key length under an open message; unused index is ignored
    send_idle_pct = 77;
    recv_idle_pct = 23;
    write_reg(CFG_KEY_LEN, {(KEY_W-KLEN_W)'(rand_word() >> KLEN_W), 5'd3});
    write_reg(CFG_KEY_LO, rand_word());
    write_reg(CFG_IDX_UNUSED, rand_word());
    end_reg_writes();
    push_messages(64, 40);
    wait_drained();

    // Zero key length acts as one
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_KEY_LEN, {(KEY_W-KLEN_W)'(rand_word() >> KLEN_W), 5'd0});
    write_reg(CFG_KEY_HI, '0);
    write_reg(CFG_KEY_LO, rand_word());
    end_reg_writes();
    push_messages(32, -1);
    wait_drained();

    // Key length above the maximum is clamped
    write_reg(CFG_KEY_LEN, {(KEY_W-KLEN_W)'(rand_word() >> KLEN_W), 5'd31});
    write_reg(CFG_KEY_LO, '0);
    write_reg(CFG_KEY_HI, ALL_ONES);
    end_reg_writes();
    push_messages(32, -1);
    push_plain(8'h5A, 1'b1, 1'b0);
    wait_drained();

    repeat (20) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
